[design/bsdc_pkg.sv]
`timescale 1ns / 1ps

package bsdc_pkg;

  // Item kinds carried in the op field
  typedef enum logic [1:0] {
    OP_HEADER = 2'd0,
    OP_ENTRY  = 2'd1,
    OP_END    = 2'd2
  } op_e;

  // Result status codes
  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_FLAGS     = 4'd1,
    ST_SEG_LIMIT = 4'd2,
    ST_DIGEST    = 4'd3,
    ST_COUNT     = 4'd4,
    ST_INDEX     = 4'd5,
    ST_STORAGE   = 4'd6,
    ST_ID        = 4'd7,
    ST_INLINE    = 4'd8,
    ST_PLACEMENT = 4'd9,
    ST_EXTERNAL  = 4'd10,
    ST_RANGE     = 4'd11,
    ST_FINAL     = 4'd12
  } status_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_MAX_SEGMENT_BYTES  = 2'd0,
    CFG_MAX_FIELD_COUNT    = 2'd1,
    CFG_INLINE_SIZE_LIMIT  = 2'd2,
    CFG_EXTERNAL_ALIGNMENT = 2'd3
  } cfg_idx_e;

  // Entry placement codes
  localparam logic [7:0] PlaceInline   = 8'd0;
  localparam logic [7:0] PlaceExternal = 8'd1;

  // Configuration reset values
  localparam logic [63:0] MaxSegmentBytesRst  = 64'd1073741824;
  localparam logic [16:0] MaxFieldCountRst    = 17'd65536;
  localparam logic [63:0] InlineSizeLimitRst  = 64'd4096;
  localparam logic [31:0] ExternalAlignRst    = 32'd16;

  // Hard ceiling on the directory entry count
  localparam logic [32:0] MaxEntries = 33'd65536;

  // Entry counter saturation value
  localparam logic [16:0] EntriesSeenMax = 17'h1FFFF;

endpackage

[design/bsdc_in_if.sv]
`timescale 1ns / 1ps

interface bsdc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] flags;
  logic [63:0] extent;
  logic        digest_zero;
  logic [31:0] entry_count;
  logic [31:0] field_number;
  logic [63:0] stored_size;
  logic [63:0] logical_size;
  logic        content_id_zero;
  logic [7:0]  placement;
  logic [63:0] segment_offset;
  logic [31:0] alignment;

  modport source (
    output valid, op, flags, extent, digest_zero, entry_count, field_number,
           stored_size, logical_size, content_id_zero, placement,
           segment_offset, alignment,
    input  ready
  );

  modport sink (
    input  valid, op, flags, extent, digest_zero, entry_count, field_number,
           stored_size, logical_size, content_id_zero, placement,
           segment_offset, alignment,
    output ready
  );
endinterface

[design/bsdc_out_if.sv]
`timescale 1ns / 1ps

interface bsdc_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [15:0] error_entry;
  logic        finished;

  modport source (
    output valid, status, error_entry, finished,
    input  ready
  );

  modport sink (
    input  valid, status, error_entry, finished,
    output ready
  );
endinterface

[design/bulk_segment_directory_checker_top.sv]
`timescale 1ns / 1ps

// Each accepted input transaction is captured in the input register, then checked into
// the result register; the check logic sits between the two registers.
// Throughput: one transaction per cycle while the result side is not stalled.
// Reset: rst_ni clears all handshake and directory state at once and restores
// the configuration registers to their defaults.
module bulk_segment_directory_checker_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [63:0]       cfg_data_i,
  bsdc_in_if.sink           in_i,
  bsdc_out_if.source        out_o
);

  // Configuration registers
  logic [63:0] max_seg_q;
  logic [16:0] max_fc_q;
  logic [63:0] inline_lim_q;
  logic [31:0] ext_align_q;

  // Input register
  logic        s1_valid_q;
  logic [1:0]  op_q;
  logic [31:0] flags_q;
  logic [63:0] extent_q;
  logic        digest_zero_q;
  logic [31:0] entry_count_q;
  logic [31:0] field_number_q;
  logic [63:0] stored_q;
  logic [63:0] logical_q;
  logic        id_zero_q;
  logic [7:0]  place_q;
  logic [63:0] offset_q;
  logic [31:0] align_q;

  // Directory state
  logic [3:0]  latched_q, latched_d;
  logic [15:0] failing_q, failing_d;
  logic [16:0] seen_q, seen_d;
  logic [63:0] prev_end_q, prev_end_d;
  logic        saw_ext_q, saw_ext_d;
  logic [63:0] seg_ext_q, seg_ext_d;

  // Result register
  logic        out_valid_q;
  logic [3:0]  status_q;
  logic [15:0] err_entry_q;
  logic        finished_q, finished_d;

  logic        advance;
  logic        in_accept;
  logic        in_ready;

  assign advance   = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_ready  = !s1_valid_q || advance;
  assign in_i.ready = in_ready;
  assign in_accept = in_i.valid && in_ready;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_seg_q    <= bsdc_pkg::MaxSegmentBytesRst;
      max_fc_q     <= bsdc_pkg::MaxFieldCountRst;
      inline_lim_q <= bsdc_pkg::InlineSizeLimitRst;
      ext_align_q  <= bsdc_pkg::ExternalAlignRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bsdc_pkg::CFG_MAX_SEGMENT_BYTES:  max_seg_q    <= cfg_data_i;
        bsdc_pkg::CFG_MAX_FIELD_COUNT:    max_fc_q     <= cfg_data_i[16:0];
        bsdc_pkg::CFG_INLINE_SIZE_LIMIT:  inline_lim_q <= cfg_data_i;
        bsdc_pkg::CFG_EXTERNAL_ALIGNMENT: ext_align_q  <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // Hold the input valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Capture the input payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q           <= in_i.op;
      flags_q        <= in_i.flags;
      extent_q       <= in_i.extent;
      digest_zero_q  <= in_i.digest_zero;
      entry_count_q  <= in_i.entry_count;
      field_number_q <= in_i.field_number;
      stored_q       <= in_i.stored_size;
      logical_q      <= in_i.logical_size;
      id_zero_q      <= in_i.content_id_zero;
      place_q        <= in_i.placement;
      offset_q       <= in_i.segment_offset;
      align_q        <= in_i.alignment;
    end
  end

  // Header checks
  logic [3:0] hdr_status;
  always_comb begin
    if (flags_q != 32'd0) begin
      hdr_status = bsdc_pkg::ST_FLAGS;
    end else if (extent_q > max_seg_q) begin
      hdr_status = bsdc_pkg::ST_SEG_LIMIT;
    end else if ((extent_q == 64'd0) != digest_zero_q) begin
      hdr_status = bsdc_pkg::ST_DIGEST;
    end else if ((entry_count_q > {15'd0, max_fc_q}) ||
                 ({1'b0, entry_count_q} > bsdc_pkg::MaxEntries)) begin
      hdr_status = bsdc_pkg::ST_COUNT;
    end else begin
      hdr_status = bsdc_pkg::ST_OK;
    end
  end

  // Entry checks
  logic [31:0] low_mask;
  logic [63:0] expected_off;
  logic [63:0] room;
  logic [63:0] ext_end;
  logic        align_pow2;
  logic        ext_bad;
  logic        range_bad;
  logic [3:0]  ent_status;

  assign low_mask     = align_q - 32'd1;
  assign expected_off = (prev_end_q + {32'd0, low_mask}) & ~{32'd0, low_mask};
  assign room         = seg_ext_q - offset_q;
  assign ext_end      = offset_q + stored_q;
  assign align_pow2   = (align_q != 32'd0) && ((align_q & low_mask) == 32'd0);
  assign ext_bad      = (stored_q <= inline_lim_q) || (align_q != ext_align_q) ||
                        !align_pow2 || ((offset_q[31:0] & low_mask) != 32'd0) ||
                        (offset_q != expected_off);
  assign range_bad    = (offset_q > seg_ext_q) || (stored_q > room);

  always_comb begin
    if (field_number_q != ({15'd0, seen_q} + 32'd1)) begin
      ent_status = bsdc_pkg::ST_INDEX;
    end else if ((flags_q != 32'd0) || (stored_q != logical_q)) begin
      ent_status = bsdc_pkg::ST_STORAGE;
    end else if (id_zero_q) begin
      ent_status = bsdc_pkg::ST_ID;
    end else if (place_q == bsdc_pkg::PlaceInline) begin
      if ((offset_q != 64'd0) || (align_q != 32'd1) || (stored_q > inline_lim_q)) begin
        ent_status = bsdc_pkg::ST_INLINE;
      end else begin
        ent_status = bsdc_pkg::ST_OK;
      end
    end else if (place_q != bsdc_pkg::PlaceExternal) begin
      ent_status = bsdc_pkg::ST_PLACEMENT;
    end else if (ext_bad) begin
      ent_status = bsdc_pkg::ST_EXTERNAL;
    end else if (range_bad) begin
      ent_status = bsdc_pkg::ST_RANGE;
    end else begin
      ent_status = bsdc_pkg::ST_OK;
    end
  end

  // Next directory state for the item in the input register
  always_comb begin
    latched_d  = latched_q;
    failing_d  = failing_q;
    seen_d     = seen_q;
    prev_end_d = prev_end_q;
    saw_ext_d  = saw_ext_q;
    seg_ext_d  = seg_ext_q;
    finished_d = 1'b0;
    unique case (op_q)
      bsdc_pkg::OP_HEADER: begin
        failing_d  = 16'd0;
        seen_d     = 17'd0;
        prev_end_d = 64'd0;
        saw_ext_d  = 1'b0;
        seg_ext_d  = extent_q;
        latched_d  = hdr_status;
      end
      bsdc_pkg::OP_ENTRY: begin
        if (latched_q == bsdc_pkg::ST_OK) begin
          if (ent_status != bsdc_pkg::ST_OK) begin
            latched_d = ent_status;
            failing_d = seen_q[15:0];
          end else if (place_q == bsdc_pkg::PlaceExternal) begin
            prev_end_d = ext_end;
            saw_ext_d  = 1'b1;
          end
          if (seen_q != bsdc_pkg::EntriesSeenMax) begin
            seen_d = seen_q + 17'd1;
          end
        end
      end
      bsdc_pkg::OP_END: begin
        finished_d = 1'b1;
        if (latched_q == bsdc_pkg::ST_OK) begin
          if (saw_ext_q ? (prev_end_q != seg_ext_q) : (seg_ext_q != 64'd0)) begin
            latched_d = bsdc_pkg::ST_FINAL;
            failing_d = 16'd0;
          end
        end
      end
      default: ;
    endcase
  end

  // Advance directory state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latched_q  <= bsdc_pkg::ST_OK;
      failing_q  <= 16'd0;
      seen_q     <= 17'd0;
      prev_end_q <= 64'd0;
      saw_ext_q  <= 1'b0;
      seg_ext_q  <= 64'd0;
    end else if (advance) begin
      latched_q  <= latched_d;
      failing_q  <= failing_d;
      seen_q     <= seen_d;
      prev_end_q <= prev_end_d;
      saw_ext_q  <= saw_ext_d;
      seg_ext_q  <= seg_ext_d;
    end
  end

  // Hold the result valid flag until the transaction is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Load the result payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      status_q    <= latched_d;
      err_entry_q <= failing_d;
      finished_q  <= finished_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = status_q;
  assign out_o.error_entry = err_entry_q;
  assign out_o.finished    = finished_q;

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  // Op value with no item kind behind it
  localparam logic [1:0] OpUnused = 2'd3;
  // Cycles without any transaction before the run is abandoned
  localparam int unsigned StallLimit = 2000;
  // Cycles to let the result pipeline settle
  localparam int unsigned SettleCycles = 6;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] flags;
    logic [63:0] extent;
    logic        digest_zero;
    logic [31:0] entry_count;
    logic [31:0] field_number;
    logic [63:0] stored_size;
    logic [63:0] logical_size;
    logic        content_id_zero;
    logic [7:0]  placement;
    logic [63:0] segment_offset;
    logic [31:0] alignment;
  } dir_item_t;

  typedef struct {
    logic [3:0]  status;
    logic [15:0] error_entry;
    logic        finished;
  } dir_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [63:0] cfg_data_i;

  bsdc_in_if  in_if ();
  bsdc_out_if out_if ();

  bulk_segment_directory_checker_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Shadow of the configuration registers
  logic [63:0] lim_seg_bytes   = bsdc_pkg::MaxSegmentBytesRst;
  logic [16:0] lim_field_count = bsdc_pkg::MaxFieldCountRst;
  logic [63:0] lim_inline_size = bsdc_pkg::InlineSizeLimitRst;
  logic [31:0] lim_ext_align   = bsdc_pkg::ExternalAlignRst;

  // Directory walk state of the predictor
  bsdc_pkg::status_e dir_latched = bsdc_pkg::ST_OK;
  logic [15:0] dir_failing   = '0;
  logic [16:0] dir_seen      = '0;
  logic [63:0] dir_prev_end  = '0;
  logic        dir_saw_ext   = 1'b0;
  logic [63:0] dir_extent    = '0;

  dir_result_t expected_status_q[$];
  int unsigned fail_count   = 0;
  int unsigned items_sent   = 0;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_idle_pct  = 0;
  int unsigned quiet_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Randomly stall the result side
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  function automatic dir_item_t blank_item(input logic [1:0] op);
    dir_item_t it;
    it = '{default: '0};
    it.op = op;
    return it;
  endfunction

  function automatic dir_item_t header_item(input logic [31:0] flags, input logic [63:0] extent,
                                            input logic dz, input logic [31:0] count);
    dir_item_t it;
    it = blank_item(bsdc_pkg::OP_HEADER);
    it.flags       = flags;
    it.extent      = extent;
    it.digest_zero = dz;
    it.entry_count = count;
    return it;
  endfunction

  function automatic dir_item_t entry_item(input logic [31:0] fnum, input logic [63:0] size,
                                           input logic [7:0] place, input logic [63:0] off,
                                           input logic [31:0] align);
    dir_item_t it;
    it = blank_item(bsdc_pkg::OP_ENTRY);
    it.field_number   = fnum;
    it.stored_size    = size;
    it.logical_size   = size;
    it.placement      = place;
    it.segment_offset = off;
    it.alignment      = align;
    return it;
  endfunction

  // Advance the directory walk by one item and return the status it reports
  function automatic dir_result_t predict_result(input dir_item_t it);
    dir_result_t       r;
    bsdc_pkg::status_e st;
    logic [63:0]       low_mask;
    logic [63:0]       aligned_pos;
    r.finished = 1'b0;
    case (it.op)
      bsdc_pkg::OP_HEADER: begin
        dir_failing  = '0;
        dir_seen     = '0;
        dir_prev_end = '0;
        dir_saw_ext  = 1'b0;
        dir_extent   = it.extent;
        if (it.flags != '0) begin
          dir_latched = bsdc_pkg::ST_FLAGS;
        end else if (it.extent > lim_seg_bytes) begin
          dir_latched = bsdc_pkg::ST_SEG_LIMIT;
        end else if ((it.extent == '0) != it.digest_zero) begin
          dir_latched = bsdc_pkg::ST_DIGEST;
        end else if (it.entry_count > lim_field_count ||
                     it.entry_count > bsdc_pkg::MaxEntries) begin
          dir_latched = bsdc_pkg::ST_COUNT;
        end else begin
          dir_latched = bsdc_pkg::ST_OK;
        end
      end
      bsdc_pkg::OP_ENTRY: begin
        if (dir_latched == bsdc_pkg::ST_OK) begin
          low_mask    = {32'd0, it.alignment - 32'd1};
          aligned_pos = (dir_prev_end + {32'd0, it.alignment} - 64'd1) & ~low_mask;
          if ({32'd0, it.field_number} != {47'd0, dir_seen} + 64'd1) begin
            st = bsdc_pkg::ST_INDEX;
          end else if (it.flags != '0 || it.stored_size != it.logical_size) begin
            st = bsdc_pkg::ST_STORAGE;
          end else if (it.content_id_zero) begin
            st = bsdc_pkg::ST_ID;
          end else if (it.placement == bsdc_pkg::PlaceInline) begin
            if (it.segment_offset != '0 || it.alignment != 32'd1 ||
                it.stored_size > lim_inline_size) begin
              st = bsdc_pkg::ST_INLINE;
            end else begin
              st = bsdc_pkg::ST_OK;
            end
          end else if (it.placement != bsdc_pkg::PlaceExternal) begin
            st = bsdc_pkg::ST_PLACEMENT;
          end else if (it.stored_size <= lim_inline_size || it.alignment != lim_ext_align ||
                       it.alignment == '0 ||
                       (it.alignment & (it.alignment - 32'd1)) != 32'd0 ||
                       (it.segment_offset & low_mask) != '0 ||
                       it.segment_offset != aligned_pos) begin
            st = bsdc_pkg::ST_EXTERNAL;
          end else if (it.segment_offset > dir_extent ||
                       it.stored_size > dir_extent - it.segment_offset) begin
            st = bsdc_pkg::ST_RANGE;
          end else begin
            st = bsdc_pkg::ST_OK;
            dir_prev_end = it.segment_offset + it.stored_size;
            dir_saw_ext  = 1'b1;
          end
          if (st != bsdc_pkg::ST_OK) begin
            dir_latched = st;
            dir_failing = dir_seen[15:0];
          end
          // Saturate the entry counter
          if (dir_seen != bsdc_pkg::EntriesSeenMax) dir_seen = dir_seen + 17'd1;
        end
      end
      bsdc_pkg::OP_END: begin
        r.finished = 1'b1;
        if (dir_latched == bsdc_pkg::ST_OK) begin
          if (dir_saw_ext ? (dir_prev_end != dir_extent) : (dir_extent != '0)) begin
            dir_latched = bsdc_pkg::ST_FINAL;
            dir_failing = '0;
          end
        end
      end
      default: ;
    endcase
    r.status      = dir_latched;
    r.error_entry = dir_failing;
    return r;
  endfunction

  task automatic load_item(input dir_item_t it);
    in_if.op              <= it.op;
    in_if.flags           <= it.flags;
    in_if.extent          <= it.extent;
    in_if.digest_zero     <= it.digest_zero;
    in_if.entry_count     <= it.entry_count;
    in_if.field_number    <= it.field_number;
    in_if.stored_size     <= it.stored_size;
    in_if.logical_size    <= it.logical_size;
    in_if.content_id_zero <= it.content_id_zero;
    in_if.placement       <= it.placement;
    in_if.segment_offset  <= it.segment_offset;
    in_if.alignment       <= it.alignment;
  endtask

  // Offer one item, hold it until accepted, then record its expected status
  task automatic send_item(input dir_item_t it);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    load_item(it);
    do @(posedge clk_i); while (!in_if.ready);
    expected_status_q.push_back(predict_result(it));
    items_sent++;
  endtask

  // Hold off the input until every outstanding status has come back
  task automatic pause_until_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (expected_status_q.size() != 0);
  endtask

  task automatic write_reg(input bsdc_pkg::cfg_idx_e idx, input logic [63:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic apply_config(input logic [63:0] seg_bytes, input logic [16:0] field_count,
                              input logic [63:0] inline_size, input logic [31:0] ext_align);
    pause_until_drained();
    repeat (SettleCycles) @(posedge clk_i);
    write_reg(bsdc_pkg::CFG_MAX_SEGMENT_BYTES, seg_bytes);
    write_reg(bsdc_pkg::CFG_MAX_FIELD_COUNT, {47'd0, field_count});
    write_reg(bsdc_pkg::CFG_INLINE_SIZE_LIMIT, inline_size);
    write_reg(bsdc_pkg::CFG_EXTERNAL_ALIGNMENT, {32'd0, ext_align});
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    lim_seg_bytes   = seg_bytes;
    lim_field_count = field_count;
    lim_inline_size = inline_size;
    lim_ext_align   = ext_align;
  endtask

  // Build a well-formed directory for the current limits, sometimes break one item
  task automatic run_directory();
    dir_item_t   dir_q[$];
    dir_item_t   it;
    int unsigned n;
    int unsigned k;
    int unsigned pick;
    logic [63:0] pos;
    logic [63:0] sz;
    logic [63:0] off;
    logic [63:0] al;
    logic [63:0] flip;
    logic [31:0] count;
    logic [31:0] small_lim;
    bit          ext_ok;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
    al = {32'd0, lim_ext_align};
    ext_ok = (lim_inline_size < 64'h100_0000_0000);
    small_lim = (lim_inline_size > 64'd4096) ? 32'd4096 : lim_inline_size[31:0];
    pos = '0;
    for (k = 0; k < n; k++) begin
      if (ext_ok && $urandom_range(0, 1) == 1) begin
        sz  = lim_inline_size + 64'd1 + 64'($urandom_range(0, 3000));
        off = (pos + al - 64'd1) & ~(al - 64'd1);
        dir_q.push_back(entry_item(32'(k + 1), sz, bsdc_pkg::PlaceExternal, off,
                                   lim_ext_align));
        pos = off + sz;
      end else begin
        dir_q.push_back(entry_item(32'(k + 1), 64'($urandom_range(0, small_lim)),
                                   bsdc_pkg::PlaceInline, '0, 32'd1));
      end
    end
    // Declare fewer entries than follow when the limit is below the real count
    count = (n <= lim_field_count) ? n : {15'd0, lim_field_count};
    dir_q.push_front(header_item('0, pos, pos == '0, count));
    if ($urandom_range(0, 9) != 0) dir_q.push_back(blank_item(bsdc_pkg::OP_END));
    if ($urandom_range(0, 3) == 0) begin
      pick = $urandom_range(0, dir_q.size() - 1);
      it   = dir_q[pick];
      flip = 64'd1 << $urandom_range(0, 63);
      case ($urandom_range(0, 8))
        0: it.flags = it.flags ^ (32'd1 << $urandom_range(0, 31));
        1: it.field_number = it.field_number ^ (32'd1 << $urandom_range(0, 31));
        2: it.logical_size = it.logical_size ^ flip;
        3: begin
          it.content_id_zero = ~it.content_id_zero;
          it.digest_zero     = ~it.digest_zero;
        end
        4: it.placement = 8'($urandom_range(0, 255));
        5: it.segment_offset = it.segment_offset ^ flip;
        6: it.alignment = it.alignment ^ (32'd1 << $urandom_range(0, 31));
        7: begin
          it.extent       = it.extent ^ flip;
          it.stored_size  = it.stored_size ^ flip;
          it.logical_size = it.logical_size ^ flip;
        end
        default: begin
          it.entry_count = $urandom;
          it.op          = 2'($urandom_range(0, 3));
        end
      endcase
      dir_q[pick] = it;
    end
    foreach (dir_q[i]) send_item(dir_q[i]);
  endtask

  // Mostly whole directories, with noise items and drain pauses mixed in
  task automatic test_random_directories(input int unsigned n_items);
    int unsigned first;
    dir_item_t   it;
    first = items_sent;
    while (items_sent - first < n_items) begin
      case ($urandom_range(0, 19))
        0, 1: begin
          it.op              = 2'($urandom_range(0, 3));
          it.flags           = $urandom;
          it.extent          = {$urandom, $urandom};
          it.digest_zero     = 1'($urandom_range(0, 1));
          it.entry_count     = $urandom;
          it.field_number    = $urandom;
          it.stored_size     = {$urandom, $urandom};
          it.logical_size    = {$urandom, $urandom};
          it.content_id_zero = 1'($urandom_range(0, 1));
          it.placement       = 8'($urandom_range(0, 255));
          it.segment_offset  = {$urandom, $urandom};
          it.alignment       = $urandom;
          send_item(it);
        end
        2: pause_until_drained();
        default: run_directory();
      endcase
    end
  endtask

  // Items before any header run against an empty segment
  task automatic test_reset_state();
    send_item(entry_item(32'd1, 64'd5, bsdc_pkg::PlaceInline, '0, 32'd1));
    send_item(entry_item(32'd2, 64'd4097, bsdc_pkg::PlaceExternal, '0, 32'd16));
    send_item(blank_item(bsdc_pkg::OP_END));
    send_item(blank_item(OpUnused));
  endtask

  task automatic test_header_checks();
    send_item(header_item('1, '0, 1'b1, '0));
    send_item(header_item('0, '1, 1'b0, '0));
    send_item(header_item('0, '0, 1'b0, '0));
    send_item(header_item('0, 64'd64, 1'b1, '0));
    send_item(header_item('0, '0, 1'b1, '1));
    send_item(entry_item(32'd1, '0, bsdc_pkg::PlaceInline, '0, 32'd1));
    send_item(header_item('0, '0, 1'b1, 32'd65536));
    send_item(blank_item(bsdc_pkg::OP_END));
  endtask

  // One inline and two chained external entries that fill the extent exactly
  task automatic test_good_directory();
    send_item(header_item('0, 64'd9105, 1'b0, 32'd3));
    send_item(entry_item(32'd1, 64'd4096, bsdc_pkg::PlaceInline, '0, 32'd1));
    send_item(entry_item(32'd2, 64'd5000, bsdc_pkg::PlaceExternal, '0, 32'd16));
    send_item(entry_item(32'd3, 64'd4097, bsdc_pkg::PlaceExternal, 64'd5008, 32'd16));
    send_item(blank_item(bsdc_pkg::OP_END));
  endtask

  task automatic test_entry_errors();
    dir_item_t it;
    send_item(header_item('0, '0, 1'b1, 32'd1));
    send_item(entry_item(32'd2, '0, bsdc_pkg::PlaceInline, '0, 32'd1));
    send_item(header_item('0, '0, 1'b1, 32'd1));
    it = entry_item(32'd1, '0, bsdc_pkg::PlaceInline, '0, 32'd1);
    it.flags = 32'd1;
    send_item(it);
    send_item(header_item('0, '0, 1'b1, 32'd1));
    it = entry_item(32'd1, '0, bsdc_pkg::PlaceInline, '0, 32'd1);
    it.content_id_zero = 1'b1;
    send_item(it);
    send_item(header_item('0, '0, 1'b1, 32'd1));
    send_item(entry_item(32'd1, '0, bsdc_pkg::PlaceInline, 64'd8, 32'd1));
    send_item(header_item('0, '0, 1'b1, 32'd1));
    send_item(entry_item(32'd1, '0, 8'hFF, '0, 32'd1));
    send_item(header_item('0, 64'd8192, 1'b0, 32'd1));
    send_item(entry_item(32'd1, 64'd8192, bsdc_pkg::PlaceExternal, '0, 32'd8));
    send_item(header_item('0, 64'd8192, 1'b0, 32'd1));
    send_item(entry_item(32'd1, 64'd8193, bsdc_pkg::PlaceExternal, '0, 32'd16));
    send_item(header_item('0, 64'd8192, 1'b0, 32'd1));
    send_item(blank_item(bsdc_pkg::OP_END));
  endtask

  task automatic test_config_extremes();
    apply_config('1, 17'd0, '0, 32'd1);
    test_random_directories(80);
    apply_config('0, 17'd65536, '1, 32'hFFFF_FFFF);
    test_random_directories(80);
    apply_config(64'h100_0000_0000, 17'd5, 64'd100, 32'h8000_0000);
    test_random_directories(80);
  endtask

  // Run well past the declared count, then fail one entry
  task automatic test_surplus_entries();
    int unsigned k;
    send_item(header_item('0, '0, 1'b1, 32'd2));
    for (k = 1; k <= 40; k++) begin
      send_item(entry_item(32'(k), '0, bsdc_pkg::PlaceInline, '0, 32'd1));
    end
    send_item(entry_item(32'd7, '0, bsdc_pkg::PlaceInline, '0, 32'd1));
    send_item(blank_item(bsdc_pkg::OP_END));
  endtask

  // Compare each returned status with the oldest prediction
  always @(posedge clk_i) begin : check_results
    dir_result_t want;
    if (out_if.valid && out_if.ready) begin
      if (expected_status_q.size() == 0) begin
        $display("%0t: unexpected result: status %0d error_entry %0d finished %0d",
                 $time, out_if.status, out_if.error_entry, out_if.finished);
        fail_count++;
      end else begin
        want = expected_status_q.pop_front();
        if (out_if.status !== want.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want.status, out_if.status);
          fail_count++;
        end
        if (out_if.error_entry !== want.error_entry) begin
          $display("%0t: error_entry mismatch: expected %0d, actual %0d",
                   $time, want.error_entry, out_if.error_entry);
          fail_count++;
        end
        if (out_if.finished !== want.finished) begin
          $display("%0t: finished mismatch: expected %0d, actual %0d",
                   $time, want.finished, out_if.finished);
          fail_count++;
        end
      end
    end
  end

  // Abandon the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni     <= 1'b0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= bsdc_pkg::CFG_MAX_SEGMENT_BYTES;
    cfg_data_i <= '0;
    in_if.valid <= 1'b0;
    load_item(blank_item(bsdc_pkg::OP_HEADER));
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Slow receiver
    tx_idle_pct = 12;
    rx_idle_pct = 77;
    test_reset_state();
    test_header_checks();
    test_good_directory();
    test_entry_errors();
    test_random_directories(200);

    // Slow sender
    tx_idle_pct = 77;
    rx_idle_pct = 12;
    test_config_extremes();

    // Back to back
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    apply_config(64'h10_0000, 17'd8, 64'd64, 32'd8);
    test_random_directories(150);
    test_surplus_entries();

    pause_until_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
